// ----- hw/rtl/lsr_pkg.sv -----
// Shared constants and request codes for the line segment rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsr_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Request kind carried in s_tuser
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lsr_setup.sv -----
// Line setup: picks the major axis and orders the endpoints along it.
// Pure combinational logic; depends on lsr_pkg.
`default_nettype none

module lsr_setup #(
    parameter int COORD_BITS = lsr_pkg::COORD_BITS_DEF
) (
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    output logic                       major_is_x,
    output logic [COORD_BITS-1:0]      major_start,
    output logic [COORD_BITS-1:0]      major_end,
    output logic [COORD_BITS-1:0]      minor_start,
    output logic [COORD_BITS-1:0]      major_span,
    output logic signed [COORD_BITS:0] minor_delta,
    output logic                       has_points
);
    import lsr_pkg::*;

    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic [COORD_BITS-1:0] minor_stop;

    // Absolute spans on both axes
    always_comb begin
        abs_dx = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
        abs_dy = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
    end

    // Major axis choice and endpoint ordering; ties go to y
    always_comb begin
        major_is_x = (abs_dx > abs_dy);
        if (major_is_x) begin
            if (start_x <= end_x) begin
                major_start = start_x;
                minor_start = start_y;
                major_end   = end_x;
                minor_stop  = end_y;
            end else begin
                major_start = end_x;
                minor_start = end_y;
                major_end   = start_x;
                minor_stop  = start_y;
            end
        end else begin
            if (start_y <= end_y) begin
                major_start = start_y;
                minor_start = start_x;
                major_end   = end_y;
                minor_stop  = end_x;
            end else begin
                major_start = end_y;
                minor_start = end_x;
                major_end   = start_y;
                minor_stop  = start_x;
            end
        end
        major_span  = major_end - major_start;
        minor_delta = $signed({1'b0, minor_stop}) - $signed({1'b0, minor_start});
        has_points  = (major_span != '0);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lsr_stepper.sv -----
// Line state and per-step point generation with an incremental remainder.
// Depends on lsr_pkg and lsr_setup.
`default_nettype none

module lsr_stepper #(
    parameter int COORD_BITS = lsr_pkg::COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  req_valid,
    input  wire lsr_pkg::opcode_t      req_op,
    input  wire logic [COORD_BITS-1:0] req_start_x,
    input  wire logic [COORD_BITS-1:0] req_start_y,
    input  wire logic [COORD_BITS-1:0] req_end_x,
    input  wire logic [COORD_BITS-1:0] req_end_y,
    output logic                       res_valid,
    output logic [COORD_BITS-1:0]      res_x,
    output logic [COORD_BITS-1:0]      res_y,
    output logic                       res_last,
    output logic                       line_active
);
    import lsr_pkg::*;

    logic                       su_major_is_x;
    logic [COORD_BITS-1:0]      su_major_start;
    logic [COORD_BITS-1:0]      su_major_end;
    logic [COORD_BITS-1:0]      su_minor_start;
    logic [COORD_BITS-1:0]      su_major_span;
    logic signed [COORD_BITS:0] su_minor_delta;
    logic                       su_has_points;

    logic                       line_active_reg;
    logic                       major_is_x_reg;
    logic [COORD_BITS-1:0]      major_pos_reg;
    logic [COORD_BITS-1:0]      major_end_reg;
    logic [COORD_BITS-1:0]      minor_pos_reg;
    logic [COORD_BITS-1:0]      major_span_reg;
    logic signed [COORD_BITS:0] minor_delta_reg;
    logic [COORD_BITS-1:0]      step_rem_reg;

    logic                       line_active_next;
    logic [COORD_BITS-1:0]      major_pos_next;
    logic [COORD_BITS-1:0]      minor_pos_next;
    logic [COORD_BITS-1:0]      step_rem_next;

    logic signed [COORD_BITS+1:0] rem_sum;
    logic signed [COORD_BITS+1:0] span_ext;
    logic signed [COORD_BITS+1:0] rem_adj;
    logic                         is_final;
    logic                         do_step;
    logic                         do_start;

    lsr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x     (req_start_x),
        .start_y     (req_start_y),
        .end_x       (req_end_x),
        .end_y       (req_end_y),
        .major_is_x  (su_major_is_x),
        .major_start (su_major_start),
        .major_end   (su_major_end),
        .minor_start (su_minor_start),
        .major_span  (su_major_span),
        .minor_delta (su_minor_delta),
        .has_points  (su_has_points)
    );

    assign do_start = req_valid && (req_op == OP_START);
    assign do_step  = req_valid && (req_op == OP_STEP) && line_active_reg;

    // Final point when the next major position reaches the exclusive end
    assign is_final = ({1'b0, major_pos_reg} + 1'b1) == {1'b0, major_end_reg};

    // Remainder update: one add, then a compare and correction by the span
    always_comb begin
        span_ext = $signed({2'b00, major_span_reg});
        rem_sum  = $signed({2'b00, step_rem_reg}) + {minor_delta_reg[COORD_BITS], minor_delta_reg};
        rem_adj  = rem_sum;
        minor_pos_next = minor_pos_reg;
        if (rem_sum >= span_ext) begin
            rem_adj        = rem_sum - span_ext;
            minor_pos_next = minor_pos_reg + 1'b1;
        end else if (rem_sum < 0) begin
            rem_adj        = rem_sum + span_ext;
            minor_pos_next = minor_pos_reg - 1'b1;
        end
        step_rem_next    = rem_adj[COORD_BITS-1:0];
        major_pos_next   = major_pos_reg + 1'b1;
        line_active_next = line_active_reg && !is_final;
    end

    // Point coordinates for the current step
    always_comb begin
        res_valid = do_step;
        res_last  = is_final;
        if (major_is_x_reg) begin
            res_x = major_pos_reg;
            res_y = minor_pos_reg;
        end else begin
            res_x = minor_pos_reg;
            res_y = major_pos_reg;
        end
    end

    assign line_active = line_active_reg;

    // Line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
        end else if (do_start) begin
            line_active_reg <= su_has_points;
        end else if (do_step) begin
            line_active_reg <= line_active_next;
        end
    end

    // Line payload, no reset needed
    always_ff @(posedge aclk) begin
        if (do_start) begin
            major_is_x_reg  <= su_major_is_x;
            major_pos_reg   <= su_major_start;
            major_end_reg   <= su_major_end;
            minor_pos_reg   <= su_minor_start;
            major_span_reg  <= su_major_span;
            minor_delta_reg <= su_minor_delta;
            step_rem_reg    <= '0;
        end else if (do_step) begin
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            step_rem_reg  <= step_rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lsr_outbuf.sv -----
// Result register with a skid stage so s_tready never depends on m_tready.
// Depends on lsr_pkg.
`default_nettype none

module lsr_outbuf #(
    parameter int WIDTH = 2 * lsr_pkg::COORD_BITS_DEF + 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  in_room,
    output logic                  out_valid,
    output logic [WIDTH-1:0]      out_data,
    input  wire logic             out_ready
);
    import lsr_pkg::*;

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_room   = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Data: skid drains first, new results fill behind
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/line_segment_rasterizer.sv -----
// Line segment rasterizer: a start request loads two endpoints, each step
// request returns one point of the line, the final one flagged by m_tlast.
// An accepted step request's point reaches m_tdata through the output register.
// Throughput: one request per cycle; s_tready drops only while both entries
// of the two-entry output buffer hold points under m_tready back-pressure.
// Reset: synchronous active-low aresetn clears the line and both buffers.
`default_nettype none

module line_segment_rasterizer #(
    parameter int COORD_BITS = lsr_pkg::COORD_BITS_DEF,
    localparam int S_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // start_x, start_y, end_x, end_y (lowest bits first), zero padded
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // opcode
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // point_x, point_y (lowest bits first), zero padded
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast
);
    import lsr_pkg::*;

    localparam int RES_W = 2 * COORD_BITS + 1;

    logic                  req_valid;
    opcode_t               req_op;
    logic                  res_valid;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic                  res_last;
    logic                  line_active;
    logic [RES_W-1:0]      buf_data;

    assign req_valid = s_tvalid && s_tready;
    assign req_op    = opcode_t'(s_tuser);

    lsr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (req_valid),
        .req_op      (req_op),
        .req_start_x (s_tdata[COORD_BITS-1:0]),
        .req_start_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .req_end_x   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .req_end_y   (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .res_valid   (res_valid),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_last    (res_last),
        .line_active (line_active)
    );

    lsr_outbuf #(
        .WIDTH (RES_W)
    ) u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   ({res_last, res_y, res_x}),
        .in_room   (s_tready),
        .out_valid (m_tvalid),
        .out_data  (buf_data),
        .out_ready (m_tready)
    );

    // Unpack the buffered point onto the master side
    assign m_tdata = M_DATA_W'(buf_data[2*COORD_BITS-1:0]);
    assign m_tlast = buf_data[RES_W-1];

    // Back-pressure only when both buffer entries hold points
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with empty output register");

    // After every produced point the master side holds valid data in the next cycle
    a_point_out: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_tvalid)
        else $error("produced point not presented");

    // The final point ends the line
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_last |=> !line_active)
        else $error("line still active after final point");

endmodule

`default_nettype wire

// ----- tb/lsr_checker.sv -----
// Checker for the line segment rasterizer: watches the request and result channels,
// predicts every line point and compares it with what the block returns.
// Depends on lsr_pkg for the request codes and the coordinate width.
module lsr_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // start_x, start_y, end_x, end_y (lowest bits first)
    input  wire logic [47:0] s_tdata,
    // opcode
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // point_x, point_y (lowest bits first)
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lsr_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int CMASK     = (1 << CW) - 1;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } line_point_t;

    // expected points, oldest first
    line_point_t points_due[$];

    // line walker state
    bit line_on;
    bit x_major;
    int maj_pos;
    int maj_stop;
    int min_pos;
    int maj_span;
    int min_delta;
    int err_acc;

    // append one expected point behind the others
    function automatic void add_due(input line_point_t pt);
        points_due = {points_due, pt};
    endfunction

    // set up a new segment from its two endpoints
    function automatic void load_segment(input int sx, input int sy,
                                         input int ex, input int ey);
        int adx, ady, a0, b0, a1, b1;
        adx = (ex >= sx) ? ex - sx : sx - ex;
        ady = (ey >= sy) ? ey - sy : sy - ey;
        if (adx > ady) begin
            x_major = 1'b1;
            if (sx <= ex) begin
                a0 = sx; b0 = sy; a1 = ex; b1 = ey;
            end else begin
                a0 = ex; b0 = ey; a1 = sx; b1 = sy;
            end
        end else begin
            x_major = 1'b0;
            if (sy <= ey) begin
                a0 = sy; b0 = sx; a1 = ey; b1 = ex;
            end else begin
                a0 = ey; b0 = ex; a1 = sy; b1 = sx;
            end
        end
        maj_pos   = a0;
        maj_stop  = a1;
        min_pos   = b0;
        maj_span  = a1 - a0;
        min_delta = b1 - b0;
        err_acc   = 0;
        line_on   = (maj_span != 0);
    endfunction

    // emit the current point and advance along the major axis
    function automatic line_point_t next_point();
        line_point_t pt;
        pt.x    = x_major ? maj_pos[CW-1:0] : min_pos[CW-1:0];
        pt.y    = x_major ? min_pos[CW-1:0] : maj_pos[CW-1:0];
        pt.last = (maj_pos + 1 == maj_stop);
        maj_pos = (maj_pos + 1) & CMASK;
        err_acc = err_acc + min_delta;
        if (err_acc >= maj_span) begin
            err_acc = err_acc - maj_span;
            min_pos = (min_pos + 1) & CMASK;
        end else if (err_acc < 0) begin
            err_acc = err_acc + maj_span;
            min_pos = (min_pos - 1) & CMASK;
        end
        if (pt.last)
            line_on = 1'b0;
        return pt;
    endfunction

    // sample both channels at the rising edge
    always @(posedge aclk) begin : watch
        line_point_t got, want;
        if (!aresetn) begin
            line_on    = 1'b0;
            x_major    = 1'b0;
            maj_pos    = 0;
            maj_stop   = 0;
            min_pos    = 0;
            maj_span   = 0;
            min_delta  = 0;
            err_acc    = 0;
            fail_count = 0;
            points_due.delete();
        end else begin
            // returned point against the oldest expectation
            if (m_tvalid && m_tready) begin
                got.x    = m_tdata[CW-1:0];
                got.y    = m_tdata[2*CW-1:CW];
                got.last = m_tlast;
                if (points_due.size() == 0) begin
                    if (fail_count < MAX_SHOWN)
                        $display("%t unexpected point x=%0d y=%0d last=%0b",
                                 $realtime, got.x, got.y, got.last);
                    fail_count++;
                end else begin
                    want = points_due.pop_front();
                    if (got.x !== want.x || got.y !== want.y
                            || got.last !== want.last) begin
                        if (fail_count < MAX_SHOWN)
                            $display({"%t point mismatch: exp x=%0d y=%0d last=%0b,",
                                      " got x=%0d y=%0d last=%0b"},
                                     $realtime, want.x, want.y, want.last,
                                     got.x, got.y, got.last);
                        fail_count++;
                    end
                end
            end
            // accepted request updates the walker
            if (s_tvalid && s_tready) begin
                if (opcode_t'(s_tuser) == OP_START)
                    load_segment(s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
                                 s_tdata[3*CW-1:2*CW], s_tdata[4*CW-1:3*CW]);
                else if (line_on)
                    add_due(next_point());
            end
        end
        pending = points_due.size();
    end

endmodule

// ----- tb/tb_line_segment_rasterizer.sv -----
// Testbench top for the line segment rasterizer: drives start and step
// requests with random gaps and back-pressure and gives the verdict.
// Depends on lsr_pkg, line_segment_rasterizer and lsr_checker.
module tb_line_segment_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import lsr_pkg::*;

    localparam int CMAX       = (1 << COORD_BITS_DEF) - 1;
    localparam int STEP_ITEMS = 1350;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending;
    int sent;
    int stall_left;
    bit no_idle;

    line_segment_rasterizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lsr_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic int clip(input int v);
        return (v < 0) ? 0 : (v > CMAX) ? CMAX : v;
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (no_idle || !aresetn) begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= idle_len();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one request, held until accepted; returns at the following falling edge
    task automatic send_req(input opcode_t op, input int ax, input int ay,
                            input int bx, input int by);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {by[11:0], bx[11:0], ay[11:0], ax[11:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    task automatic step_req();
        send_req(OP_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    // hold off the sender until every expected point is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    // a start followed by about as many steps as the line has points
    task automatic random_line();
        int r, reach, sx, sy, ex, ey, span, steps;
        r = $urandom_range(0, 99);
        if (r < 80)
            reach = $urandom_range(0, 12);
        else if (r < 97)
            reach = $urandom_range(13, 60);
        else
            reach = $urandom_range(61, 300);
        sx = $urandom_range(0, CMAX);
        sy = $urandom_range(0, CMAX);
        ex = clip(sx + $urandom_range(0, 2 * reach) - reach);
        ey = clip(sy + $urandom_range(0, 2 * reach) - reach);
        send_req(OP_START, sx, sy, ex, ey);
        span = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > span)
            span = (ey > sy) ? ey - sy : sy - ey;
        // sometimes cut short so the next start drops an active line
        if ($urandom_range(0, 99) < 10)
            steps = $urandom_range(0, span);
        else
            steps = span + $urandom_range(0, 2);
        repeat (steps) step_req();
    endtask

    // stimulus
    initial begin
        no_idle = 1'b0;
        sent    = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: step with nothing loaded, degenerate lines
        step_req();
        send_req(OP_START, 0, 0, 0, 0);
        step_req();
        send_req(OP_START, CMAX, CMAX, CMAX, CMAX);
        step_req();
        // equal spans, y major
        send_req(OP_START, 0, 0, 3, 3);
        repeat (4) step_req();
        // x major, reversed endpoints near the top corner
        send_req(OP_START, CMAX, CMAX, CMAX - 5, CMAX - 2);
        repeat (5) step_req();
        // full-height line, then restart while still active
        send_req(OP_START, 0, CMAX, 2, 0);
        repeat (2) step_req();
        // full-width line with falling minor
        send_req(OP_START, CMAX, 0, 0, CMAX - 1);
        repeat (2) step_req();
        // flat line, then y major with x going down
        send_req(OP_START, 10, 20, 13, 20);
        repeat (3) step_req();
        send_req(OP_START, 20, 10, 17, 14);
        repeat (4) step_req();
        drain();

        // random lines mixed with stray requests
        while (sent < STEP_ITEMS) begin
            no_idle = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 10)
                send_req(opcode_t'($urandom_range(0, 1)), $urandom, $urandom,
                         $urandom, $urandom);
            else
                random_line();
            if ($urandom_range(0, 99) < 3)
                drain();
        end

        // wind down: receiver always ready, wait for every point
        no_idle = 1'b1;
        s_tvalid <= 1'b0;
        for (int i = 0; i < 100000 && pending != 0; i++) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_line_segment_rasterizer: PASS");
        end else begin
            $display("tb_line_segment_rasterizer: FAIL");
        end
        $finish;
    end

    // overall run limit
    initial begin
        #10_000_000;
        $display("tb_line_segment_rasterizer: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lsr_pkg.sv
hw/rtl/lsr_setup.sv
hw/rtl/lsr_stepper.sv
hw/rtl/lsr_outbuf.sv
hw/rtl/line_segment_rasterizer.sv
tb/lsr_checker.sv
tb/tb_line_segment_rasterizer.sv
